FILE: hw/rtl/scbs_pkg.sv
package scbs_pkg;

    localparam int REPLY_BYTES = 5;

    // bit counters must hold 8 * REPLY_BYTES
    localparam int BIT_CNT_W  = $clog2(8 * REPLY_BYTES + 1);
    localparam int BYTE_NUM_W = BIT_CNT_W - 3;

    localparam logic [7:0] FRAME_HEADER_RST = 8'hcc;
    localparam logic [7:0] ACK_CODE_RST     = 8'ha5;
    localparam logic [7:0] ACTION_NONE      = 8'hfe;

    // command codes
    localparam logic [7:0] CMD_ACT_85    = 8'h85;
    localparam logic [7:0] CMD_ACT_87    = 8'h87;
    localparam logic [7:0] CMD_ACT_8B    = 8'h8b;
    localparam logic [7:0] CMD_ACT_8D    = 8'h8d;
    localparam logic [7:0] CMD_ACT_LO    = 8'h93;
    localparam logic [7:0] CMD_ACT_HI    = 8'h99;
    localparam logic [7:0] CMD_RD_VOLT   = 8'h84;
    localparam logic [7:0] CMD_RD_TEMP   = 8'h86;
    localparam logic [7:0] CMD_RD_ACTION = 8'h88;

    // request types
    localparam logic [1:0] REQ_EDGE       = 2'd0;
    localparam logic [1:0] REQ_HOST_WRITE = 2'd1;
    localparam logic [1:0] REQ_DONE       = 2'd2;

    // reply sources
    localparam logic [1:0] SRC_ACK    = 2'd0;
    localparam logic [1:0] SRC_ACTION = 2'd1;
    localparam logic [1:0] SRC_VOLT   = 2'd2;
    localparam logic [1:0] SRC_TEMP   = 2'd3;

    // configuration register indexes
    localparam logic CFG_FRAME_HEADER = 1'b0;
    localparam logic CFG_ACK_CODE     = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic       bus_in_bit;
        logic       buffer_select;
        logic [2:0] byte_index;
        logic [7:0] byte_value;
    } in_word_t;

    typedef struct packed {
        logic       bus_out_bit;
        logic [7:0] pending_action;
        logic       sending;
    } out_word_t;

    typedef struct packed {
        logic                 start;
        logic                 latch;
        logic [1:0]           source;
        logic [BIT_CNT_W-1:0] total;
    } cmd_dec_t;

endpackage

FILE: hw/rtl/scbs_cmd_decode.sv
module scbs_cmd_decode (
    input  logic [7:0]        cmd,
    output scbs_pkg::cmd_dec_t dec
);
    import scbs_pkg::*;

    logic is_action;

    assign is_action = (cmd >= CMD_ACT_LO && cmd <= CMD_ACT_HI) || cmd == CMD_ACT_85 ||
                       cmd == CMD_ACT_87 || cmd == CMD_ACT_8B || cmd == CMD_ACT_8D;

    // unknown codes fall through with start low
    always_comb begin
        dec.start  = 1'b0;
        dec.latch  = 1'b0;
        dec.source = SRC_ACK;
        dec.total  = BIT_CNT_W'(8);
        if (is_action) begin
            dec.start = 1'b1;
            dec.latch = 1'b1;
        end else if (cmd == CMD_RD_ACTION) begin
            dec.start  = 1'b1;
            dec.source = SRC_ACTION;
        end else if (cmd == CMD_RD_VOLT) begin
            dec.start  = 1'b1;
            dec.source = SRC_VOLT;
            dec.total  = BIT_CNT_W'(8 * REPLY_BYTES);
        end else if (cmd == CMD_RD_TEMP) begin
            dec.start  = 1'b1;
            dec.source = SRC_TEMP;
            dec.total  = BIT_CNT_W'(8 * REPLY_BYTES);
        end
    end

endmodule

FILE: hw/rtl/serial_command_bus_slave_core.sv
// Serial command bus slave core.
// s_ channel: one word per event: a bus clock edge (with the data-in level),
// a host write of a reply byte, or a host "action done" mark.
// m_ channel: exactly one word per input word, giving the serial output
// level, the pending action code and the sending flag after that event.
// cfg_ port: frame header (index 0) and ack code (index 1); write only
// while no word is in flight.
// Latency: the result word is valid the cycle after the input is taken.
// Throughput: one word per cycle while results are taken; all state updates for a
// word are done in one pass of logic ahead of the result register.
// Reset (aresetn low, synchronous): idle, shift register and reply stores
// cleared, action code 0xfe, output level 1, no result word held.
// When the receiver stalls, the result word is held and s_ready drops
// until it is taken; s_ready stays high while the result is taken in the
// same cycle.
module serial_command_bus_slave_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  scbs_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output scbs_pkg::out_word_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [7:0]           cfg_wr_data
);
    import scbs_pkg::*;

    logic [7:0]           frame_header_reg;
    logic [7:0]           ack_code_reg;
    logic [15:0]          shift_reg, shift_next;
    logic                 sending_reg, sending_next;
    logic [BIT_CNT_W-1:0] sent_reg, sent_next;
    logic [BIT_CNT_W-1:0] total_reg, total_next;
    logic [1:0]           source_reg, source_next;
    logic [7:0]           action_reg, action_next;
    logic [7:0]           volt_reg [REPLY_BYTES];
    logic [7:0]           temp_reg [REPLY_BYTES];
    logic                 out_level_reg, out_level_next;
    logic                 m_valid_reg;
    out_word_t            m_data_reg;

    logic                 accept;
    logic [15:0]          shifted;
    cmd_dec_t             dec;
    logic [BYTE_NUM_W-1:0] byte_num;
    logic [7:0]           volt_byte, temp_byte, reply_byte;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign shifted = {shift_reg[14:0], s_data.bus_in_bit};

    scbs_cmd_decode u_dec (
        .cmd (shifted[7:0]),
        .dec (dec)
    );

    // reply byte selected from the live source
    assign byte_num = sent_reg[BIT_CNT_W-1:3];

    always_comb begin
        volt_byte = 8'h00;
        temp_byte = 8'h00;
        for (int i = 0; i < REPLY_BYTES; i++) begin
            if (byte_num == BYTE_NUM_W'(i)) begin
                volt_byte = volt_reg[i];
                temp_byte = temp_reg[i];
            end
        end
    end

    always_comb begin
        unique case (source_reg)
            SRC_ACK:    reply_byte = ack_code_reg;
            SRC_ACTION: reply_byte = action_reg;
            SRC_VOLT:   reply_byte = volt_byte;
            default:    reply_byte = temp_byte;
        endcase
    end

    always_comb begin
        shift_next     = shift_reg;
        sending_next   = sending_reg;
        sent_next      = sent_reg;
        total_next     = total_reg;
        source_next    = source_reg;
        action_next    = action_reg;
        out_level_next = out_level_reg;
        unique case (s_data.req_type)
            REQ_EDGE: begin
                if (!sending_reg) begin
                    shift_next = shifted;
                    if (shifted[15:8] == frame_header_reg && dec.start) begin
                        sending_next = 1'b1;
                        sent_next    = '0;
                        total_next   = dec.total;
                        source_next  = dec.source;
                        if (dec.latch) begin
                            action_next = shifted[7:0];
                        end
                    end
                end else if (sent_reg < total_reg) begin
                    out_level_next = reply_byte[~sent_reg[2:0]];
                    sent_next      = sent_reg + BIT_CNT_W'(1);
                end else begin
                    // trailing edge: release the line
                    out_level_next = 1'b1;
                    sent_next      = '0;
                    total_next     = '0;
                    sending_next   = 1'b0;
                end
            end
            REQ_DONE: action_next = ACTION_NONE;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_header_reg <= FRAME_HEADER_RST;
            ack_code_reg     <= ACK_CODE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FRAME_HEADER: frame_header_reg <= cfg_wr_data;
                default:          ack_code_reg     <= cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0;
            sending_reg   <= 1'b0;
            sent_reg      <= '0;
            total_reg     <= '0;
            source_reg    <= SRC_ACK;
            action_reg    <= ACTION_NONE;
            out_level_reg <= 1'b1;
            for (int i = 0; i < REPLY_BYTES; i++) begin
                volt_reg[i] <= 8'h00;
                temp_reg[i] <= 8'h00;
            end
        end else if (accept) begin
            shift_reg     <= shift_next;
            sending_reg   <= sending_next;
            sent_reg      <= sent_next;
            total_reg     <= total_next;
            source_reg    <= source_next;
            action_reg    <= action_next;
            out_level_reg <= out_level_next;
            if (s_data.req_type == REQ_HOST_WRITE) begin
                for (int i = 0; i < REPLY_BYTES; i++) begin
                    if (s_data.byte_index == 3'(i)) begin
                        if (s_data.buffer_select) begin
                            temp_reg[i] <= s_data.byte_value;
                        end else begin
                            volt_reg[i] <= s_data.byte_value;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.bus_out_bit    <= out_level_next;
            m_data_reg.pending_action <= action_next;
            m_data_reg.sending        <= sending_next;
        end
    end

    // idle means both bit counters are clear
    a_idle_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> (sent_reg == '0 && total_reg == '0))
        else $error("bit counters not clear while idle");

    a_sent_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sent_reg <= total_reg)
        else $error("bits sent beyond reply length");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.req_type == REQ_DONE |=> action_reg == ACTION_NONE)
        else $error("action not cleared by done request");

    a_reply_end: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.req_type == REQ_EDGE && sending_reg && sent_reg == total_reg
        |=> !sending_reg && out_level_reg && m_data_reg.bus_out_bit)
        else $error("reply did not end with line released");

endmodule
